// ===== rtl/core/rtclt_pkg.sv =====
// Shared types and constants for the raw clock snapshot to local time converter.
`timescale 1ns / 1ps

package rtclt_pkg;

	localparam logic signed [4:0] TZ_RESET_HOURS = 5'sd8;
	localparam logic [7:0] DEFAULT_CENTURY = 8'd20;

	localparam logic [7:0] MONTH_LEN [12] = '{
		8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
		8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
	};

	typedef enum logic [1:0] {
		SHIFT_NONE,
		SHIFT_UP,
		SHIFT_DN
	} shift_t;

	typedef struct packed {
		logic [7:0] raw_second;
		logic [7:0] raw_minute;
		logic [7:0] raw_hour;
		logic [7:0] raw_day;
		logic [7:0] raw_month;
		logic [7:0] raw_year;
		logic [7:0] raw_century;
		logic [7:0] raw_weekday;
		logic       binary_mode;
		logic       hour_24_mode;
	} raw_time_t;

	typedef struct packed {
		logic [15:0] local_year;
		logic [7:0]  local_month;
		logic [7:0]  local_day;
		logic [4:0]  local_hour;
		logic [7:0]  local_minute;
		logic [7:0]  local_second;
		logic [7:0]  local_weekday;
	} local_time_t;

	// decoded snapshot, hour already offset; date not yet rolled
	typedef struct packed {
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [4:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [7:0]  weekday;
		logic        leap;
		shift_t      shift;
	} dec_time_t;

endpackage

// ===== rtl/core/rtclt_decode.sv =====
// Field decode, 12/24-hour conversion, hour offset, leap year and weekday shift.
`timescale 1ns / 1ps

module rtclt_decode (
	input  rtclt_pkg::raw_time_t  raw,
	input  logic signed [4:0]     tz_offset_hours,
	output rtclt_pkg::dec_time_t  dec
);

	function automatic logic [7:0] bcd8(input logic [7:0] v, input logic bin);
		logic [7:0] r;
		if (bin) begin
			r = v;
		end else begin
			r = 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
		end
		return r;
	endfunction

	logic              pm;
	logic [7:0]        hr_pre;
	logic [7:0]        hr_dec;
	logic [7:0]        hr_12;
	logic [4:0]        hr_sat;
	logic signed [6:0] h_sum;
	logic [7:0]        cen_dec;
	logic [7:0]        yr_dec;
	logic [7:0]        yr_mod;
	logic [1:0]        yr_hund;
	logic [1:0]        cen_lsb;
	logic [7:0]        wd_dec;

	always_comb begin
		pm     = !raw.hour_24_mode && raw.raw_hour[7];
		hr_pre = raw.hour_24_mode ? raw.raw_hour : {1'b0, raw.raw_hour[6:0]};
		hr_dec = bcd8(hr_pre, raw.binary_mode);

		hr_12 = hr_dec;
		if (!raw.hour_24_mode) begin
			if (pm) begin
				if (hr_dec < 8'd12) hr_12 = hr_dec + 8'd12;
			end else if (hr_dec == 8'd12) begin
				hr_12 = 8'd0;
			end
		end
		hr_sat = (hr_12 > 8'd23) ? 5'd23 : hr_12[4:0];

		h_sum = $signed({2'b00, hr_sat}) + $signed({{2{tz_offset_hours[4]}}, tz_offset_hours});
		dec.shift = rtclt_pkg::SHIFT_NONE;
		dec.hour  = h_sum[4:0];
		if (h_sum >= 7'sd24) begin
			dec.shift = rtclt_pkg::SHIFT_UP;
			dec.hour  = 5'(h_sum - 7'sd24);
		end else if (h_sum < 7'sd0) begin
			dec.shift = rtclt_pkg::SHIFT_DN;
			dec.hour  = 5'(h_sum + 7'sd24);
		end

		cen_dec = (raw.raw_century == 8'd0) ? rtclt_pkg::DEFAULT_CENTURY
			: bcd8(raw.raw_century, raw.binary_mode);
		yr_dec  = bcd8(raw.raw_year, raw.binary_mode);

		// year mod 100 and year / 100 from the two-digit byte alone
		if (yr_dec >= 8'd200) begin
			yr_mod  = yr_dec - 8'd200;
			yr_hund = 2'd2;
		end else if (yr_dec >= 8'd100) begin
			yr_mod  = yr_dec - 8'd100;
			yr_hund = 2'd1;
		end else begin
			yr_mod  = yr_dec;
			yr_hund = 2'd0;
		end
		cen_lsb  = cen_dec[1:0] + yr_hund;
		dec.leap = ((yr_mod != 8'd0) && (yr_mod[1:0] == 2'd0))
			|| ((yr_mod == 8'd0) && (cen_lsb == 2'd0));
		dec.year = 16'(cen_dec) * 16'd100 + 16'(yr_dec);

		dec.month  = bcd8(raw.raw_month, raw.binary_mode);
		dec.day    = bcd8(raw.raw_day, raw.binary_mode);
		dec.minute = bcd8(raw.raw_minute, raw.binary_mode);
		dec.second = bcd8(raw.raw_second, raw.binary_mode);

		wd_dec      = bcd8(raw.raw_weekday, raw.binary_mode);
		dec.weekday = wd_dec;
		if ((wd_dec >= 8'd1) && (wd_dec <= 8'd7)) begin
			unique case (dec.shift)
				rtclt_pkg::SHIFT_UP: dec.weekday = (wd_dec == 8'd7) ? 8'd1 : wd_dec + 8'd1;
				rtclt_pkg::SHIFT_DN: dec.weekday = (wd_dec == 8'd1) ? 8'd7 : wd_dec - 8'd1;
				default:             dec.weekday = wd_dec;
			endcase
		end
	end

endmodule

// ===== rtl/core/rtc_raw_to_local_time.sv =====
// Top level: raw clock register snapshot to local calendar time.
`timescale 1ns / 1ps

// One request per clock is taken whenever start is high; busy never rises.
// Each request yields one result, shown on result for one cycle with done
// high, after passing the input register, then decode and date roll into the
// result register. The receiver cannot stall, so results must be taken as
// they appear. tz_offset_hours is written through cfg_valid / cfg_data
// (always ready), resets to +8, and must only change while no request is in
// flight.
module rtc_raw_to_local_time (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  rtclt_pkg::raw_time_t    raw,
	output logic                    done,
	output rtclt_pkg::local_time_t  result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic signed [4:0]       cfg_data
);

	function automatic logic [7:0] days_in(input logic [7:0] m, input logic leap);
		logic [7:0] d;
		if ((m < 8'd1) || (m > 8'd12)) begin
			d = 8'd31;
		end else if ((m == 8'd2) && leap) begin
			d = 8'd29;
		end else begin
			d = rtclt_pkg::MONTH_LEN[4'(m - 8'd1)];
		end
		return d;
	endfunction

	logic signed [4:0]       tz_q;
	rtclt_pkg::raw_time_t    raw_s1;
	logic                    vld_s1;
	rtclt_pkg::dec_time_t    dec;
	rtclt_pkg::local_time_t  res;
	rtclt_pkg::local_time_t  res_s2;
	logic                    vld_s2;
	logic [7:0]              prev_mon;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q <= rtclt_pkg::TZ_RESET_HOURS;
		end else if (cfg_valid && cfg_ready) begin
			tz_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) raw_s1 <= raw;
		if (vld_s1) res_s2 <= res;
	end

	rtclt_decode u_decode (
		.raw             (raw_s1),
		.tz_offset_hours (tz_q),
		.dec             (dec)
	);

	// day carry / borrow into month and year
	always_comb begin
		prev_mon           = (dec.month == 8'd1) ? 8'd12 : dec.month - 8'd1;
		res.local_year     = dec.year;
		res.local_month    = dec.month;
		res.local_day      = dec.day;
		res.local_hour     = dec.hour;
		res.local_minute   = dec.minute;
		res.local_second   = dec.second;
		res.local_weekday  = dec.weekday;
		unique case (dec.shift)
			rtclt_pkg::SHIFT_UP: begin
				if (dec.day < days_in(dec.month, dec.leap)) begin
					res.local_day = dec.day + 8'd1;
				end else begin
					res.local_day = 8'd1;
					if (dec.month == 8'd12) begin
						res.local_month = 8'd1;
						res.local_year  = dec.year + 16'd1;
					end else begin
						res.local_month = dec.month + 8'd1;
					end
				end
			end
			rtclt_pkg::SHIFT_DN: begin
				if (dec.day > 8'd1) begin
					res.local_day = dec.day - 8'd1;
				end else begin
					res.local_month = prev_mon;
					res.local_day   = days_in(prev_mon, dec.leap);
					if (dec.month == 8'd1) res.local_year = dec.year - 16'd1;
				end
			end
			default: begin
				res.local_day = dec.day;
			end
		endcase
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule
